[hw/rtl/bap_pkg.sv]
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types, field widths, register codes and defaults of the block
// average pixelate unit.
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int PIX_W      = 8;
    localparam int IDX_W      = 10;
    localparam int FRAME_W    = 11;
    localparam int BLOCK_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_BLOCK  = 64;

    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [BLOCK_W-1:0] RST_BLOCK_SIZE   = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BLOCK_SIZE   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_blue;
    } pixel_t;

    typedef struct packed {
        logic [IDX_W-1:0] block_col;
        logic [IDX_W-1:0] block_row;
        logic [PIX_W-1:0] avg_red;
        logic [PIX_W-1:0] avg_green;
        logic [PIX_W-1:0] avg_blue;
        logic             frame_last;
    } block_t;

    typedef struct packed {
        logic seg_end;
        logic rows_end;
        logic frame_end;
        logic first_row;
    } pos_flags_t;

endpackage

[hw/rtl/bap_pos.sv]
// ----------------------------------------------------------------------------
// bap_pos
// Raster position tracker: pixel position, offsets inside the current block,
// block indexes and the segment, block and frame boundary flags.
// ----------------------------------------------------------------------------
module bap_pos
    import bap_pkg::*;
#(
    parameter int XW  = 10,
    parameter int YW  = 10,
    parameter int WCW = 11,
    parameter int HCW = 11,
    parameter int BCW = 7,
    parameter int OW  = 6
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           restart,
    input  logic           advance,
    input  logic [WCW-1:0] w_eff,
    input  logic [HCW-1:0] h_eff,
    input  logic [BCW-1:0] bs_eff,
    output logic [OW-1:0]  xoff,
    output logic [OW-1:0]  yoff,
    output logic [XW-1:0]  bc,
    output logic [YW-1:0]  br,
    output pos_flags_t     flags
);

    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [OW-1:0] xoff_reg;
    logic [OW-1:0] yoff_reg;
    logic [XW-1:0] bc_reg;
    logic [YW-1:0] br_reg;

    logic line_end;
    logic last_line;
    logic xwrap;
    logic ywrap;

    always_comb begin
        line_end  = (WCW'(x_reg) + WCW'(1)) == w_eff;
        last_line = (HCW'(y_reg) + HCW'(1)) == h_eff;
        xwrap     = (BCW'(xoff_reg) + BCW'(1)) == bs_eff;
        ywrap     = (BCW'(yoff_reg) + BCW'(1)) == bs_eff;
        flags.seg_end   = xwrap || line_end;
        flags.rows_end  = ywrap || last_line;
        flags.frame_end = line_end && last_line;
        flags.first_row = (yoff_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            x_reg    <= '0;
            y_reg    <= '0;
            xoff_reg <= '0;
            yoff_reg <= '0;
            bc_reg   <= '0;
            br_reg   <= '0;
        end else if (advance) begin
            if (line_end) begin
                x_reg    <= '0;
                xoff_reg <= '0;
                bc_reg   <= '0;
                if (last_line) begin
                    y_reg    <= '0;
                    yoff_reg <= '0;
                    br_reg   <= '0;
                end else begin
                    y_reg <= y_reg + YW'(1);
                    if (ywrap) begin
                        yoff_reg <= '0;
                        br_reg   <= br_reg + YW'(1);
                    end else begin
                        yoff_reg <= yoff_reg + OW'(1);
                    end
                end
            end else begin
                x_reg <= x_reg + XW'(1);
                if (xwrap) begin
                    xoff_reg <= '0;
                    bc_reg   <= bc_reg + XW'(1);
                end else begin
                    xoff_reg <= xoff_reg + OW'(1);
                end
            end
        end
    end

    assign xoff = xoff_reg;
    assign yoff = yoff_reg;
    assign bc   = bc_reg;
    assign br   = br_reg;

endmodule

[hw/rtl/bap_div.sv]
// ----------------------------------------------------------------------------
// bap_div
// Three-lane truncating divider by a small count, built as a multiply by a
// rounded-up reciprocal from a constant table. The product is registered.
// ----------------------------------------------------------------------------
module bap_div
    import bap_pkg::*;
#(
    parameter int MAX_BLOCK = DEF_MAX_BLOCK,
    parameter int SUM_W     = 14,
    parameter int OFF_W     = 6
) (
    input  logic                       aclk,
    input  logic                       start,
    input  logic [2:0][SUM_W-1:0]      dividend,
    input  logic [OFF_W-1:0]           divisor_m1,
    output logic [2:0][PIX_W-1:0]      quot
);

    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int K  = SUM_W + BW;
    localparam int RW = K + 1;
    localparam int PW = SUM_W + RW;
    localparam int TD = 1 << OFF_W;

    logic [RW-1:0] recip_tab [TD];
    logic [RW-1:0] recip;
    logic [2:0][PW-1:0] prod_reg;

    for (genvar g = 0; g < TD; g++) begin : g_rcp
        if (g < MAX_BLOCK) begin : g_used
            localparam longint unsigned Rcp = ((64'd1 << K) + g) / (g + 1);
            assign recip_tab[g] = RW'(Rcp);
        end else begin : g_unused
            assign recip_tab[g] = '0;
        end
    end

    assign recip = recip_tab[divisor_m1];

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PW'(dividend[i]) * PW'(recip);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quot[i] = prod_reg[i][K +: PIX_W];
        end
    end

endmodule

[hw/rtl/bap_mem.sv]
// ----------------------------------------------------------------------------
// bap_mem
// Per block column store of the running row-average sums, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module bap_mem
    import bap_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = 10,
    parameter int DW    = 42
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/block_average_pixelate_unit.sv]
// ----------------------------------------------------------------------------
// block_average_pixelate_unit
// A pixel inside a row segment leaves the unit idle; a segment end passes through
// S_SEG and S_UPD for the read-modify-write of the column sum memory through the
// divider; a block end then passes S_BLK and S_EMIT, which waits while the previous
// result beat is held, and raises its result beat. Reset selects 1024 x 1024 frames
// with 8-pixel blocks from the top-left pixel; column sums are not cleared.
// ----------------------------------------------------------------------------
module block_average_pixelate_unit
    import bap_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_t                s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output block_t                m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int OW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > FRAME_W) ? $clog2(MAX_WIDTH + 1) : FRAME_W;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > FRAME_W) ? $clog2(MAX_HEIGHT + 1) : FRAME_W;
    localparam int BCW = ($clog2(MAX_BLOCK + 1) > BLOCK_W) ? $clog2(MAX_BLOCK + 1) : BLOCK_W;
    localparam int SW  = $clog2(MAX_BLOCK * 255 + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG,
        S_UPD,
        S_BLK,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;
    logic [BLOCK_W-1:0] block_size_reg;

    logic [WCW-1:0] w_raw, w_eff;
    logic [HCW-1:0] h_raw, h_eff;
    logic [BCW-1:0] bs_raw, bs_eff;

    logic       cfg_accept;
    logic       cfg_restart;
    logic       s_accept;

    logic [OW-1:0] xoff_cur, yoff_cur;
    logic [XW-1:0] bc_cur;
    logic [YW-1:0] br_cur;
    pos_flags_t    pos_flags;

    logic [2:0][SW-1:0] seg_sum_reg;
    logic [2:0][SW-1:0] seg_sum_next;
    logic [2:0][SW-1:0] acc_reg;
    logic [2:0][SW-1:0] acc_next;
    logic [2:0][SW-1:0] mem_rd;

    pos_flags_t    flags_reg;
    logic [OW-1:0] xoff_reg, yoff_reg;
    logic [XW-1:0] bc_reg;
    logic [YW-1:0] br_reg;

    logic                 div_start;
    logic [2:0][SW-1:0]   div_dividend;
    logic [OW-1:0]        div_divisor_m1;
    logic [2:0][PIX_W-1:0] div_quot;

    logic   mem_we, mem_re;
    logic   m_valid_reg;
    block_t m_data_reg;

    always_comb begin
        w_raw  = WCW'(frame_width_reg);
        h_raw  = HCW'(frame_height_reg);
        bs_raw = BCW'(block_size_reg);
        w_eff  = (w_raw == '0) ? WCW'(1) :
                 (w_raw > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_raw;
        h_eff  = (h_raw == '0) ? HCW'(1) :
                 (h_raw > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_raw;
        bs_eff = (bs_raw == '0) ? BCW'(1) :
                 (bs_raw > BCW'(MAX_BLOCK)) ? BCW'(MAX_BLOCK) : bs_raw;
    end

    always_comb begin
        case (cfg_index)
            CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_BLOCK_SIZE: cfg_restart = cfg_accept;
            default: cfg_restart = 1'b0;
        endcase
    end

    assign cfg_ready  = (state_reg == S_IDLE);
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_ready    = (state_reg == S_IDLE) && !cfg_valid;
    assign s_accept   = s_valid && s_ready;

    bap_pos #(
        .XW  (XW),
        .YW  (YW),
        .WCW (WCW),
        .HCW (HCW),
        .BCW (BCW),
        .OW  (OW)
    ) u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_restart),
        .advance (s_accept),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .bs_eff  (bs_eff),
        .xoff    (xoff_cur),
        .yoff    (yoff_cur),
        .bc      (bc_cur),
        .br      (br_cur),
        .flags   (pos_flags)
    );

    always_comb begin
        seg_sum_next[0] = seg_sum_reg[0] + SW'(s_data.pixel_red);
        seg_sum_next[1] = seg_sum_reg[1] + SW'(s_data.pixel_green);
        seg_sum_next[2] = seg_sum_reg[2] + SW'(s_data.pixel_blue);
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = (flags_reg.first_row ? '0 : mem_rd[i]) + SW'(div_quot[i]);
        end
    end

    assign div_start      = (state_reg == S_SEG) || (state_reg == S_BLK);
    assign div_dividend   = (state_reg == S_SEG) ? seg_sum_reg : acc_reg;
    assign div_divisor_m1 = (state_reg == S_SEG) ? xoff_reg : yoff_reg;

    bap_div #(
        .MAX_BLOCK (MAX_BLOCK),
        .SUM_W     (SW),
        .OFF_W     (OW)
    ) u_div (
        .aclk       (aclk),
        .start      (div_start),
        .dividend   (div_dividend),
        .divisor_m1 (div_divisor_m1),
        .quot       (div_quot)
    );

    assign mem_re = (state_reg == S_SEG);
    assign mem_we = (state_reg == S_UPD);

    bap_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW),
        .DW    (3 * SW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (bc_reg),
        .wr_data (acc_next),
        .rd_en   (mem_re),
        .rd_addr (bc_reg),
        .rd_data (mem_rd)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            flags_reg <= pos_flags;
            xoff_reg  <= xoff_cur;
            yoff_reg  <= yoff_cur;
            bc_reg    <= bc_cur;
            br_reg    <= br_cur;
        end
        if (state_reg == S_UPD) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            seg_sum_reg      <= '0;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            block_size_reg   <= RST_BLOCK_SIZE;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        seg_sum_reg <= seg_sum_next;
                        if (pos_flags.seg_end) begin
                            state_reg <= S_SEG;
                        end
                    end
                end
                S_SEG: begin
                    seg_sum_reg <= '0;
                    state_reg   <= S_UPD;
                end
                S_UPD: begin
                    state_reg <= flags_reg.rows_end ? S_BLK : S_IDLE;
                end
                S_BLK: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.block_col  <= IDX_W'(bc_reg);
                        m_data_reg.block_row  <= IDX_W'(br_reg);
                        m_data_reg.avg_red    <= div_quot[0];
                        m_data_reg.avg_green  <= div_quot[1];
                        m_data_reg.avg_blue   <= div_quot[2];
                        m_data_reg.frame_last <= flags_reg.frame_end;
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_restart) begin
                seg_sum_reg <= '0;
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_W-1:0];
                    CFG_BLOCK_SIZE:   block_size_reg   <= cfg_data[BLOCK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Every write-back of a column sum completes the read issued in the cycle before it.
    a_rmw_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> $past(state_reg == S_SEG))
        else $error("column sum written without a preceding read");

    // A result beat is only raised for a pixel that closes a block.
    a_emit_block: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_EMIT) && flags_reg.rows_end)
        else $error("result raised outside a block end");

    // A pixel that does not close a segment leaves the unit idle for the next beat.
    a_fast_path: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !pos_flags.seg_end |=> state_reg == S_IDLE)
        else $error("mid-segment pixel did not return to idle");

    // A write to the width, height or block size register restarts the frame at the top-left with empty segment sums.
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_restart |=> xoff_cur == '0 && yoff_cur == '0 && bc_cur == '0
                        && br_cur == '0 && seg_sum_reg == '0)
        else $error("register write did not restart the frame");

endmodule

[tb/block_average_pixelate_unit_tb.sv]
// ----------------------------------------------------------------------------
// block_average_pixelate_unit_tb
// Streams raster-order pixels through the mosaic averaging unit for a range of
// frame and block geometries. Register extremes are covered, including zero,
// oversized and masked values, and so is a write to the spare register index.
// A scoreboard keeps its own block-average prediction and compares every
// result beat with it, field by field. Both channels throttle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_average_pixelate_unit_tb
    import bap_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 100;

    class block_avg_scoreboard;
        bit [FRAME_W-1:0] width_reg  = RST_FRAME_WIDTH;
        bit [FRAME_W-1:0] height_reg = RST_FRAME_HEIGHT;
        bit [BLOCK_W-1:0] bsize_reg  = RST_BLOCK_SIZE;
        bit [IDX_W-1:0]   col_pos;
        bit [IDX_W-1:0]   row_pos;
        bit [13:0]        seg_sum [3];
        bit [13:0]        row_avg_sum [DEF_MAX_WIDTH][3];
        block_t           expected_blocks [$];
        int               errors;

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void restart_frame();
            col_pos = '0;
            row_pos = '0;
            foreach (seg_sum[c]) seg_sum[c] = '0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg = val;
                CFG_FRAME_HEIGHT: height_reg = val;
                CFG_BLOCK_SIZE:   bsize_reg = val[BLOCK_W-1:0];
                default:          return;
            endcase
            restart_frame();
        endfunction

        function void note_pixel(pixel_t px);
            int unsigned w, h, bs, x, y, bc, xoff, yoff;
            bit [PIX_W-1:0] chan [3];
            bit line_end, frame_end, seg_end, rows_end;
            block_t blk;
            w  = clamp_size(width_reg, DEF_MAX_WIDTH);
            h  = clamp_size(height_reg, DEF_MAX_HEIGHT);
            bs = clamp_size(bsize_reg, DEF_MAX_BLOCK);
            if (col_pos >= w || row_pos >= h) restart_frame();
            x = col_pos;
            y = row_pos;
            chan[0] = px.pixel_red;
            chan[1] = px.pixel_green;
            chan[2] = px.pixel_blue;
            bc        = x / bs;
            xoff      = x % bs;
            yoff      = y % bs;
            line_end  = (x + 1 == w);
            frame_end = line_end && (y + 1 == h);
            seg_end   = (xoff + 1 == bs) || line_end;
            rows_end  = (yoff + 1 == bs) || (y + 1 == h);
            foreach (chan[c]) seg_sum[c] += chan[c];
            if (seg_end) begin
                foreach (chan[c]) begin
                    if (yoff == 0) begin
                        row_avg_sum[bc][c] = seg_sum[c] / (xoff + 1);
                    end else begin
                        row_avg_sum[bc][c] += seg_sum[c] / (xoff + 1);
                    end
                    seg_sum[c] = '0;
                end
                if (rows_end) begin
                    blk.block_col  = IDX_W'(bc);
                    blk.block_row  = IDX_W'(y / bs);
                    blk.avg_red    = PIX_W'(row_avg_sum[bc][0] / (yoff + 1));
                    blk.avg_green  = PIX_W'(row_avg_sum[bc][1] / (yoff + 1));
                    blk.avg_blue   = PIX_W'(row_avg_sum[bc][2] / (yoff + 1));
                    blk.frame_last = frame_end;
                    expected_blocks.push_back(blk);
                end
            end
            if (line_end) begin
                col_pos = '0;
                row_pos = (y + 1 == h) ? '0 : IDX_W'(y + 1);
            end else begin
                col_pos = IDX_W'(x + 1);
            end
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_block(block_t got);
            block_t want;
            if (expected_blocks.size() == 0) begin
                report($sformatf("unexpected block beat col %0d row %0d",
                                 got.block_col, got.block_row));
                return;
            end
            want = expected_blocks.pop_front();
            if (got.block_col !== want.block_col)
                report($sformatf("block_col %0d, expected %0d", got.block_col, want.block_col));
            if (got.block_row !== want.block_row)
                report($sformatf("block_row %0d, expected %0d", got.block_row, want.block_row));
            if (got.avg_red !== want.avg_red)
                report($sformatf("avg_red %0d, expected %0d (block %0d,%0d)",
                                 got.avg_red, want.avg_red, want.block_col, want.block_row));
            if (got.avg_green !== want.avg_green)
                report($sformatf("avg_green %0d, expected %0d (block %0d,%0d)",
                                 got.avg_green, want.avg_green, want.block_col, want.block_row));
            if (got.avg_blue !== want.avg_blue)
                report($sformatf("avg_blue %0d, expected %0d (block %0d,%0d)",
                                 got.avg_blue, want.avg_blue, want.block_col, want.block_row));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last %0d, expected %0d (block %0d,%0d)",
                                 got.frame_last, want.frame_last, want.block_col, want.block_row));
        endtask

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pixel_t                s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    block_t                m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    block_avg_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int cycle_count;

    block_average_pixelate_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_block(m_data);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic set_idling(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    function automatic pixel_t next_pixel(input int i, input bit directed);
        pixel_t px;
        logic [PIX_W-1:0] chan [3];
        if (directed) begin
            px.pixel_red   = i[0] ? 8'hff : 8'h00;
            px.pixel_green = (i % 3 == 0) ? 8'hff : PIX_W'(i * 37);
            px.pixel_blue  = PIX_W'(255 - i * 11);
            return px;
        end
        foreach (chan[c]) begin
            case ($urandom_range(0, 9))
                0:       chan[c] = 8'h00;
                1:       chan[c] = 8'hff;
                default: chan[c] = PIX_W'($urandom);
            endcase
        end
        px.pixel_red   = chan[0];
        px.pixel_green = chan[1];
        px.pixel_blue  = chan[2];
        return px;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.note_config(idx, val);
    endtask

    task automatic send_pixel(input pixel_t px);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pixel(px);
    endtask

    // The unit is idle between runs, so register writes never race a pixel.
    task automatic run_phase(input logic [3:0] sel, input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data,
                             input logic [CFG_DATA_W-1:0] bs_data,
                             input int count, input bit directed);
        if (sel[0]) cfg_write(CFG_FRAME_WIDTH, w_data);
        if (sel[1]) cfg_write(CFG_FRAME_HEIGHT, h_data);
        if (sel[2]) cfg_write(CFG_BLOCK_SIZE, bs_data);
        if (sel[3]) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
        if (sel != 4'b0000) cfg_valid <= 1'b0;
        for (int i = 0; i < count; i++) send_pixel(next_pixel(i, directed));
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phases(input int quota);
        int sent;
        int w, h, bs, frame, n;
        logic [3:0] sel;
        logic [CFG_DATA_W-1:0] bs_data;
        sent = 0;
        while (sent < quota) begin
            w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 12);
            h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
            bs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
            bs_data = CFG_DATA_W'(bs);
            if ($urandom_range(0, 3) == 0) bs_data[CFG_DATA_W-1:BLOCK_W] = 4'($urandom);
            sel[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b111;
            sel[3]   = ($urandom_range(0, 7) == 0);
            frame = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            n = $urandom_range(1, (3 * frame < 90) ? 3 * frame : 90);
            run_phase(sel, CFG_DATA_W'(w), CFG_DATA_W'(h), bs_data, n, 1'b0);
            sent += n;
        end
    endtask

    initial begin
        sb = new();
        set_idling(28, 70);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero registers make a one-pixel frame, then a small frame with
        // clipped blocks on the right and bottom edges.
        run_phase(4'b0111, 11'd0, 11'd0, 11'd0, 3, 1'b1);
        run_phase(4'b0111, 11'd5, 11'd3, 11'd2, 15, 1'b1);
        // Oversized registers clamp to the largest frame line and block.
        run_phase(4'b0111, 11'd2047, 11'd1, 11'd127, 192, 1'b0);
        random_phases(50);

        set_idling(70, 28);
        run_phase(4'b0111, 11'd1, 11'd2047, 11'd64, 130, 1'b0);
        run_phase(4'b0111, 11'd1024, 11'd2, 11'd1, 40, 1'b0);
        random_phases(50);

        set_idling(0, 0);
        random_phases(50);

        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) sb.report($sformatf("%0d block beats never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[block_average_pixelate_unit.f]
hw/rtl/bap_pkg.sv
hw/rtl/bap_pos.sv
hw/rtl/bap_div.sv
hw/rtl/bap_mem.sv
hw/rtl/block_average_pixelate_unit.sv
tb/block_average_pixelate_unit_tb.sv
